// ===== rtl/core/pss_pkg.sv =====
// Shared types and constants for the proportional-share scheduler.
// Used by pss_div, proportional_share_scheduler_top and the testbench.
`timescale 1ns / 1ps

package pss_pkg;

    localparam int MAX_TASKS_DEF = 16;

    localparam int BURST_W   = 16;
    localparam int WEIGHT_W  = 8;
    localparam int QUANTUM_W = 16;
    localparam int TIME_W    = 20;
    localparam int ID_W      = 4;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;

    // weight * quantum
    localparam int PROD_W     = WEIGHT_W + QUANTUM_W;
    localparam int WSUM_W_DEF = $clog2(MAX_TASKS_DEF * (2 ** WEIGHT_W - 1) + 1);

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 48;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RST = 16'd10;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_GRANT = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK          = 2'd0,
        STAT_FULL        = 2'd1,
        STAT_ZERO_WEIGHT = 2'd2,
        STAT_ALL_DONE    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FIN,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/core/pss_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module pss_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/pss_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on pss_pkg for default widths.
`timescale 1ns / 1ps

module pss_div #(
    parameter int DIVIDEND_W = pss_pkg::PROD_W,
    parameter int DIVISOR_W  = pss_pkg::WSUM_W_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVISOR_W-1:0]  part_reg;
    logic [DIVISOR_W-1:0]  part_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;
    logic                  last;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        trial     = {part_reg, quo_reg[DIVIDEND_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        ge        = trial >= {1'b0, dsr_reg};
        part_next = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        last      = cnt_reg == CNT_W'(DIVIDEND_W - 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            part_reg <= '0;
            quo_reg  <= dividend;
            dsr_reg  <= divisor;
        end else if (busy_reg) begin
            part_reg <= part_next;
            quo_reg  <= {quo_reg[DIVIDEND_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/proportional_share_scheduler_top.sv =====
// Weighted round-robin time-slice scheduler, top level.
// Depends on pss_pkg, pss_ram and pss_div.
`timescale 1ns / 1ps

// One request is taken at a time; s_tready is high only while the block is idle.
// Clear, load and rejected requests go from idle to the output state, which loads
// the output register once it is free. A grant scans the finished flags one entry per
// cycle from the round-robin pointer, reads the task table, multiplies weight by
// quantum and then divides by the total weight in a restoring divider that yields
// one quotient bit per cycle. The result sits in an output register, so the next
// request may be taken while it waits for m_tready. The quantum register resets to
// 10 and is written through cfg_wr_en; the user must write it only while idle, as
// the block itself does not enforce it.

module proportional_share_scheduler_top #(
    parameter int MAX_TASKS = pss_pkg::MAX_TASKS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // task_burst [15:0], task_weight [23:16]
    input  logic [pss_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type [1:0]
    input  logic [pss_pkg::REQ_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // task_id [3:0], slice_start [23:4], slice_end [43:24], task_finished [44], zero [47:45]
    output logic [pss_pkg::M_TDATA_W-1:0]   m_tdata,
    // status [1:0]
    output logic [pss_pkg::STATUS_W-1:0]    m_tuser,
    input  logic                            cfg_wr_en,
    input  logic [pss_pkg::QUANTUM_W-1:0]   cfg_wr_data
);

    localparam int IDX_W  = $clog2(MAX_TASKS);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int WSUM_W = $clog2(MAX_TASKS * (2 ** pss_pkg::WEIGHT_W - 1) + 1);
    localparam int BW     = pss_pkg::BURST_W;
    localparam int WW     = pss_pkg::WEIGHT_W;
    localparam int QW     = pss_pkg::QUANTUM_W;
    localparam int TW     = pss_pkg::TIME_W;
    localparam int PW     = pss_pkg::PROD_W;
    localparam int IW     = pss_pkg::ID_W;
    localparam int PAD_W  = pss_pkg::M_TDATA_W - (IW + 2 * TW + 1);

    pss_pkg::state_t state_reg, state_next;

    logic [QW-1:0]        quantum_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [WSUM_W-1:0]    wsum_reg;
    logic [TW-1:0]        time_reg;
    logic [IDX_W-1:0]     np_reg;
    logic [MAX_TASKS-1:0] flags_reg;
    logic [IDX_W-1:0]     scan_idx_reg;
    logic [CNT_W-1:0]     scan_k_reg;
    logic [PW-1:0]        prod_reg;
    logic [BW-1:0]        rem_reg;

    logic [IW-1:0]        res_id_reg;
    logic [TW-1:0]        res_start_reg;
    logic [TW-1:0]        res_end_reg;
    logic                 res_fin_reg;
    pss_pkg::status_t     res_status_reg;

    logic                           m_tvalid_reg;
    logic [pss_pkg::M_TDATA_W-1:0]  m_tdata_reg;
    pss_pkg::status_t               m_tuser_reg;

    logic             accept;
    pss_pkg::req_t    in_req;
    logic [BW-1:0]    in_burst;
    logic [WW-1:0]    in_weight;
    logic             load_ok;
    logic             zero_weight;
    logic             scan_hit;
    logic             scan_last;
    logic [IDX_W-1:0] scan_wrap;
    logic [IDX_W-1:0] start_idx;
    logic [IDX_W-1:0] np_new;
    logic             out_free;

    logic [IDX_W-1:0] ram_addr;
    logic             burst_we;
    logic [BW-1:0]    burst_wdata;
    logic [BW-1:0]    burst_rdata;
    logic             weight_we;
    logic [WW-1:0]    weight_rdata;

    logic             div_start;
    logic             div_done;
    logic [PW-1:0]    div_quo;

    logic [QW-1:0]    slice;
    logic [QW-1:0]    slice_adj;
    logic [BW-1:0]    run;
    logic [TW:0]      end_sum;
    logic [TW-1:0]    end_sat;
    logic [BW-1:0]    rem_new;
    logic             fin_now;

    assign in_req    = pss_pkg::req_t'(s_tuser);
    assign in_burst  = s_tdata[BW-1:0];
    assign in_weight = s_tdata[BW+WW-1:BW];
    assign s_tready  = state_reg == pss_pkg::ST_IDLE;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        load_ok     = cnt_reg < CNT_W'(MAX_TASKS);
        zero_weight = (wsum_reg == '0) || (quantum_reg == '0);
        scan_hit    = !flags_reg[scan_idx_reg];
        scan_last   = (scan_k_reg + CNT_W'(1)) == cnt_reg;
        scan_wrap   = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == cnt_reg) ? '0
                                                                       : scan_idx_reg + IDX_W'(1);
        np_new      = scan_wrap;
        start_idx   = (CNT_W'(np_reg) < cnt_reg) ? np_reg : '0;

        slice     = div_quo[QW-1:0];
        slice_adj = (slice == '0 && rem_reg != '0) ? QW'(1) : slice;
        run       = (rem_reg < slice_adj) ? rem_reg : slice_adj;
        end_sum   = {1'b0, time_reg} + (TW + 1)'(run);
        end_sat   = end_sum[TW] ? '1 : end_sum[TW-1:0];
        rem_new   = rem_reg - run;
        fin_now   = rem_new == '0;
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pss_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        div_start   = 1'b0;
        ram_addr    = scan_idx_reg;
        burst_we    = 1'b0;
        burst_wdata = rem_new;
        weight_we   = 1'b0;
        unique case (state_reg)
            pss_pkg::ST_IDLE: begin
                ram_addr    = cnt_reg[IDX_W-1:0];
                burst_wdata = in_burst;
                if (accept) begin
                    if (in_req == pss_pkg::REQ_GRANT && !zero_weight) begin
                        state_next = pss_pkg::ST_SCAN;
                    end else begin
                        state_next = pss_pkg::ST_OUT;
                    end
                    if (in_req == pss_pkg::REQ_LOAD && load_ok) begin
                        burst_we  = 1'b1;
                        weight_we = 1'b1;
                    end
                end
            end
            pss_pkg::ST_SCAN: begin
                if (scan_hit) begin
                    state_next = pss_pkg::ST_READ;
                end else if (scan_last) begin
                    state_next = pss_pkg::ST_OUT;
                end
            end
            pss_pkg::ST_READ:     state_next = pss_pkg::ST_MUL;
            pss_pkg::ST_MUL:      state_next = pss_pkg::ST_DIV_GO;
            pss_pkg::ST_DIV_GO: begin
                div_start  = 1'b1;
                state_next = pss_pkg::ST_DIV_WAIT;
            end
            pss_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = pss_pkg::ST_FIN;
                end
            end
            pss_pkg::ST_FIN: begin
                burst_we   = 1'b1;
                state_next = pss_pkg::ST_OUT;
            end
            pss_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = pss_pkg::ST_IDLE;
                end
            end
            default: state_next = pss_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg <= pss_pkg::QUANTUM_RST;
        end else if (cfg_wr_en) begin
            quantum_reg <= cfg_wr_data;
        end
    end

    // scheduler state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            wsum_reg  <= '0;
            time_reg  <= '0;
            np_reg    <= '0;
            flags_reg <= '0;
        end else begin
            case (state_reg)
                pss_pkg::ST_IDLE: begin
                    if (accept) begin
                        if (in_req == pss_pkg::REQ_CLEAR) begin
                            cnt_reg   <= '0;
                            wsum_reg  <= '0;
                            time_reg  <= '0;
                            np_reg    <= '0;
                            flags_reg <= '0;
                        end else if (in_req == pss_pkg::REQ_LOAD && load_ok) begin
                            flags_reg[cnt_reg[IDX_W-1:0]] <= 1'b0;
                            wsum_reg <= wsum_reg + WSUM_W'(in_weight);
                            cnt_reg  <= cnt_reg + CNT_W'(1);
                        end
                    end
                end
                pss_pkg::ST_FIN: begin
                    time_reg                <= end_sat;
                    flags_reg[scan_idx_reg] <= fin_now;
                    np_reg                  <= np_new;
                end
                default: ;
            endcase
        end
    end

    // working registers and pending result
    always_ff @(posedge aclk) begin
        case (state_reg)
            pss_pkg::ST_IDLE: begin
                res_start_reg <= time_reg;
                res_end_reg   <= time_reg;
                res_fin_reg   <= 1'b0;
                res_id_reg    <= '0;
                scan_idx_reg  <= start_idx;
                scan_k_reg    <= '0;
                unique case (in_req)
                    pss_pkg::REQ_CLEAR: begin
                        res_start_reg  <= '0;
                        res_end_reg    <= '0;
                        res_status_reg <= pss_pkg::STAT_OK;
                    end
                    pss_pkg::REQ_LOAD: begin
                        if (load_ok) begin
                            res_id_reg     <= IW'(cnt_reg);
                            res_status_reg <= pss_pkg::STAT_OK;
                        end else begin
                            res_status_reg <= pss_pkg::STAT_FULL;
                        end
                    end
                    pss_pkg::REQ_GRANT: res_status_reg <= pss_pkg::STAT_ZERO_WEIGHT;
                    pss_pkg::REQ_NONE:  res_status_reg <= pss_pkg::STAT_ALL_DONE;
                    default:            res_status_reg <= pss_pkg::STAT_ALL_DONE;
                endcase
            end
            pss_pkg::ST_SCAN: begin
                if (!scan_hit) begin
                    res_status_reg <= pss_pkg::STAT_ALL_DONE;
                    if (!scan_last) begin
                        scan_k_reg   <= scan_k_reg + CNT_W'(1);
                        scan_idx_reg <= scan_wrap;
                    end
                end
            end
            pss_pkg::ST_MUL: begin
                prod_reg <= PW'(weight_rdata) * PW'(quantum_reg);
                rem_reg  <= burst_rdata;
            end
            pss_pkg::ST_FIN: begin
                res_id_reg     <= IW'(scan_idx_reg);
                res_end_reg    <= end_sat;
                res_fin_reg    <= fin_now;
                res_status_reg <= pss_pkg::STAT_OK;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (state_reg == pss_pkg::ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == pss_pkg::ST_OUT && out_free) begin
            m_tdata_reg <= {PAD_W'(0), res_fin_reg, res_end_reg, res_start_reg, res_id_reg};
            m_tuser_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    pss_ram #(
        .DATA_W (BW),
        .DEPTH  (MAX_TASKS)
    ) u_burst_ram (
        .aclk  (aclk),
        .we    (burst_we),
        .addr  (ram_addr),
        .wdata (burst_wdata),
        .rdata (burst_rdata)
    );

    pss_ram #(
        .DATA_W (WW),
        .DEPTH  (MAX_TASKS)
    ) u_weight_ram (
        .aclk  (aclk),
        .we    (weight_we),
        .addr  (ram_addr),
        .wdata (in_weight),
        .rdata (weight_rdata)
    );

    pss_div #(
        .DIVIDEND_W (PW),
        .DIVISOR_W  (WSUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (wsum_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_TASKS))
        else $error("task count beyond table size");

    a_empty_no_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == '0 |-> wsum_reg == '0)
        else $error("weight sum nonzero with empty table");

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (np_reg == '0) || (CNT_W'(np_reg) < cnt_reg))
        else $error("round-robin pointer outside table");

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == pss_pkg::ST_DIV_WAIT)
        else $error("divider finished outside wait state");

    a_slice_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg == pss_pkg::STAT_OK)
            |-> m_tdata_reg[IW+2*TW-1:IW+TW] >= m_tdata_reg[IW+TW-1:IW])
        else $error("slice ends before it starts");

endmodule

// ===== tb/sv/tb_proportional_share_scheduler_top.sv =====
// Self-checking testbench for proportional_share_scheduler_top: a scoreboard class predicts
// every slice grant, load and clear result and checks it against the stream output.
// Depends on pss_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module tb_proportional_share_scheduler_top;
    import pss_pkg::*;

    localparam int NUM_TASKS    = MAX_TASKS_DEF;
    localparam int TIME_LIMIT   = (1 << TIME_W) - 1;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 130;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] stop;
        logic              fin;
        status_t           status;
    } slice_t;

    // Scheduler state mirror; predicts one result per request transfer.
    class slice_scoreboard;
        int unsigned quantum;
        int unsigned burst_left [NUM_TASKS];
        int unsigned weight     [NUM_TASKS];
        bit          done       [NUM_TASKS];
        int unsigned count, wsum, now, ptr;
        slice_t      expected_slices[$];
        int          errors;

        function new();
            quantum = QUANTUM_RST;
            errors  = 0;
            clear_table();
        endfunction

        function void clear_table();
            foreach (done[i]) begin
                burst_left[i] = 0;
                weight[i]     = 0;
                done[i]       = 1'b0;
            end
            count = 0;
            wsum  = 0;
            now   = 0;
            ptr   = 0;
        endfunction

        function void push(int unsigned id, int unsigned t0, int unsigned t1, bit fin,
                           status_t st);
            slice_t r;
            r.id     = ID_W'(id);
            r.start  = TIME_W'(t0);
            r.stop   = TIME_W'(t1);
            r.fin    = fin;
            r.status = st;
            expected_slices.push_back(r);
        endfunction

        function status_t note_request(req_t req, logic [BURST_W-1:0] burst,
                                       logic [WEIGHT_W-1:0] wt);
            int unsigned first, j, idx, sl, run, rem, t1;
            bit found;
            found = 1'b0;
            idx   = 0;
            case (req)
                REQ_CLEAR: begin
                    clear_table();
                    push(0, 0, 0, 1'b0, STAT_OK);
                    return STAT_OK;
                end
                REQ_LOAD: begin
                    if (count >= NUM_TASKS) begin
                        push(0, now, now, 1'b0, STAT_FULL);
                        return STAT_FULL;
                    end
                    burst_left[count] = burst;
                    weight[count]     = wt;
                    done[count]       = 1'b0;
                    wsum += wt;
                    push(count, now, now, 1'b0, STAT_OK);
                    count++;
                    return STAT_OK;
                end
                REQ_GRANT: begin
                    if (wsum == 0 || quantum == 0) begin
                        push(0, now, now, 1'b0, STAT_ZERO_WEIGHT);
                        return STAT_ZERO_WEIGHT;
                    end
                    first = (ptr < count) ? ptr : 0;
                    for (int k = 0; k < count; k++) begin
                        j = first + k;
                        if (j >= count) j -= count;
                        if (!found && !done[j]) begin
                            idx   = j;
                            found = 1'b1;
                        end
                    end
                    if (!found) begin
                        push(0, now, now, 1'b0, STAT_ALL_DONE);
                        return STAT_ALL_DONE;
                    end
                    rem = burst_left[idx];
                    sl  = (weight[idx] * quantum) / wsum;
                    if (sl == 0 && rem > 0) sl = 1;
                    run = (rem < sl) ? rem : sl;
                    t1  = now + run;
                    if (t1 > TIME_LIMIT) t1 = TIME_LIMIT;
                    push(idx, now, t1, rem == run, STAT_OK);
                    now             = t1;
                    burst_left[idx] = rem - run;
                    if (rem == run) done[idx] = 1'b1;
                    ptr = (idx + 1 < count) ? idx + 1 : 0;
                    return STAT_OK;
                end
                default: begin
                    push(0, now, now, 1'b0, STAT_ALL_DONE);
                    return STAT_ALL_DONE;
                end
            endcase
        endfunction

        function void check_slice(slice_t got);
            slice_t want;
            if (expected_slices.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: id %0d start %0d end %0d fin %0d status %0d",
                             got.id, got.start, got.stop, got.fin, got.status);
                return;
            end
            want = expected_slices.pop_front();
            if (got.id !== want.id || got.start !== want.start || got.stop !== want.stop ||
                got.fin !== want.fin || got.status !== want.status) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected id %0d start %0d end %0d fin %0d status %0d, %s",
                             want.id, want.start, want.stop, want.fin, want.status,
                             $sformatf("got id %0d start %0d end %0d fin %0d status %0d",
                                       got.id, got.start, got.stop, got.fin, got.status));
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [REQ_W-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   cfg_wr_en = 1'b0;
    logic [QUANTUM_W-1:0]   cfg_wr_data = '0;

    slice_scoreboard sb;
    int      src_idle_pct = 0;
    int      sink_idle_pct = 0;
    int      items_sent = 0;
    int      stall_cycles = 0;
    status_t last_status;

    proportional_share_scheduler_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result sink, checker and watchdog
    always @(posedge aclk) begin
        slice_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.id     = m_tdata[3:0];
                got.start  = m_tdata[23:4];
                got.stop   = m_tdata[43:24];
                got.fin    = m_tdata[44];
                got.status = status_t'(m_tuser);
                sb.check_slice(got);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("[proportional_share_scheduler_top] ERROR");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    task automatic send_request(input req_t req, input logic [BURST_W-1:0] burst,
                                input logic [WEIGHT_W-1:0] wt);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {wt, burst};
        do @(posedge aclk); while (!s_tready);
        last_status = sb.note_request(req, burst, wt);
        items_sent++;
    endtask

    task automatic write_quantum(input logic [QUANTUM_W-1:0] q);
        s_tvalid <= 1'b0;
        while (sb.expected_slices.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= q;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        sb.quantum = q;
    endtask

    function automatic logic [BURST_W-1:0] pick_burst();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return BURST_W'($urandom_range(0, 12));
        if (r < 75) return r[0] ? '1 : '0;
        return BURST_W'($urandom);
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 15) return '1;
        return WEIGHT_W'($urandom);
    endfunction

    // clear, fill the table, then grant until a grant is not OK or max_grants is reached
    task automatic run_schedule(input int n_loads, input int max_grants);
        int grants;
        send_request(REQ_CLEAR, pick_burst(), pick_weight());
        repeat (n_loads) send_request(REQ_LOAD, pick_burst(), pick_weight());
        grants = 0;
        do begin
            send_request(REQ_GRANT, pick_burst(), pick_weight());
            grants++;
        end while (last_status == STAT_OK && grants < max_grants);
    endtask

    initial begin
        int q, target;
        sb = new();
        src_idle_pct  = 15;
        sink_idle_pct = 88;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, ignored request type, zero weight, full table, zero burst
        send_request(REQ_GRANT, '0, '0);
        send_request(REQ_NONE, '1, '1);
        send_request(REQ_CLEAR, '0, '0);
        send_request(REQ_LOAD, '0, '0);
        send_request(REQ_GRANT, '0, '0);
        send_request(REQ_LOAD, '1, '1);
        send_request(REQ_LOAD, '0, 8'd1);
        repeat (NUM_TASKS - 3) send_request(REQ_LOAD, pick_burst(), pick_weight());
        send_request(REQ_LOAD, 16'd7, 8'd7);
        repeat (4) send_request(REQ_GRANT, '0, '0);
        send_request(REQ_CLEAR, '0, '0);
        write_quantum('0);
        send_request(REQ_LOAD, 16'd5, 8'd3);
        send_request(REQ_GRANT, '0, '0);

        for (int p = 0; p < PHASES; p++) begin
            if (p < 3) begin
                src_idle_pct  = 15;
                sink_idle_pct = 88;
            end else if (p < 6) begin
                src_idle_pct  = 88;
                sink_idle_pct = 15;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if (p == 0) q = 1;
            else if (p == 1) q = 16'hFFFF;
            else if (p % 2) q = $urandom_range(2, 64);
            else q = $urandom_range(1, 16'hFFFF);
            write_quantum(QUANTUM_W'(q));
            target = items_sent + PHASE_ITEMS;
            if (p == 1) begin
                // longest possible timeline: full table of maximum bursts
                send_request(REQ_CLEAR, '0, '0);
                repeat (NUM_TASKS) send_request(REQ_LOAD, '1, '1);
                do send_request(REQ_GRANT, '0, '0); while (last_status == STAT_OK);
            end
            while (items_sent < target) begin
                if ($urandom_range(0, 99) < 15) begin
                    repeat ($urandom_range(1, 6))
                        send_request(req_t'($urandom_range(0, 3)), BURST_W'($urandom),
                                     WEIGHT_W'($urandom));
                end else if ($urandom_range(0, 9) == 0) begin
                    run_schedule(NUM_TASKS + $urandom_range(1, 2), 60);
                end else begin
                    run_schedule($urandom_range(1, NUM_TASKS), 60);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (sb.expected_slices.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("[proportional_share_scheduler_top] OK");
        end else begin
            $display("[proportional_share_scheduler_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pss_pkg.sv
rtl/core/pss_ram.sv
rtl/core/pss_div.sv
rtl/core/proportional_share_scheduler_top.sv
tb/sv/tb_proportional_share_scheduler_top.sv
